// File: design/bsd_pkg.sv
// shared types, codes and the per-byte step function of the bom sniffing decoder
// no dependencies; used by every module in the design folder
package bsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 3;
    localparam int CODE_W          = 21;

    localparam logic [15:0] WORD_BYTECODE = 16'hFAFA;
    localparam logic [15:0] WORD_SWAPPED  = 16'hFFFE;
    localparam logic [15:0] WORD_NATIVE   = 16'hFEFF;
    localparam logic [15:0] WORD_UTF8_BOM = 16'hBBEF;
    localparam logic [7:0]  BYTE_UTF8_END = 8'hBF;

    typedef enum logic [2:0] {
        ST_CHAR     = 3'd0,
        ST_EOS      = 3'd1,
        ST_BYTECODE = 3'd2,
        ST_IOERR    = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_BOM3   = 2'd2,
        PH_DECODE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_LE    = 2'd1,
        MODE_BE    = 2'd2,
        MODE_UTF8  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_status           status;
    } t_res;

    // all results caused by one request, oldest in slot 0
    typedef struct packed {
        logic [1:0]              cnt;
        t_res [MAX_RES-1:0]      res;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle data;
    } t_qport;

    typedef struct packed {
        t_phase            phase;
        t_mode             mode;
        logic [7:0]        held;
        logic [CODE_W-1:0] acc;
        logic [1:0]        rem;
        logic              done;
    } t_dstate;

    typedef struct packed {
        t_dstate nxt;
        t_bundle out;
    } t_step;

    localparam t_dstate DSTATE_RST = '{
        phase: PH_FIRST, mode: MODE_PLAIN, held: 8'd0,
        acc: '0, rem: 2'd0, done: 1'b0
    };

    function automatic t_bundle bsd_push(input t_bundle b, input logic [CODE_W-1:0] code,
                                         input t_status st);
        t_bundle r;
        r = b;
        r.res[b.cnt].code   = (st == ST_CHAR) ? code : '0;
        r.res[b.cnt].status = st;
        r.cnt               = b.cnt + 2'd1;
        return r;
    endfunction

    // one character code out; a zero code ends the stream
    function automatic t_step bsd_give(input t_step s, input logic [CODE_W-1:0] code);
        t_step r;
        r = s;
        if (code == '0) begin
            r.out      = bsd_push(s.out, '0, ST_EOS);
            r.nxt.done = 1'b1;
        end else begin
            r.out = bsd_push(s.out, code, ST_CHAR);
        end
        return r;
    endfunction

    function automatic t_step bsd_finish(input t_step s, input t_status st);
        t_step r;
        r          = s;
        r.out      = bsd_push(s.out, '0, st);
        r.nxt.done = 1'b1;
        return r;
    endfunction

    function automatic t_step bsd_decode(input t_step s, input logic [7:0] b);
        t_step             r;
        logic [CODE_W-1:0] acc_n;
        r     = s;
        acc_n = {s.nxt.acc[CODE_W-7:0], b[5:0]};
        unique case (s.nxt.mode)
            MODE_PLAIN: begin
                r = bsd_give(s, {13'd0, b});
            end
            MODE_LE, MODE_BE: begin
                if (s.nxt.rem == 2'd0) begin
                    r.nxt.held = b;
                    r.nxt.rem  = 2'd1;
                end else begin
                    r.nxt.rem  = 2'd0;
                    r.nxt.held = 8'd0;
                    if (s.nxt.mode == MODE_LE) begin
                        r = bsd_give(r, {5'd0, b, s.nxt.held});
                    end else begin
                        r = bsd_give(r, {5'd0, s.nxt.held, b});
                    end
                end
            end
            MODE_UTF8: begin
                if (s.nxt.rem == 2'd0) begin
                    if (!b[7]) begin
                        r = bsd_give(s, {13'd0, b});
                    end else if (b[7:6] == 2'b10) begin
                        r = bsd_finish(s, ST_EOS);
                    end else if (b[7:5] == 3'b110) begin
                        r.nxt.acc = {16'd0, b[4:0]};
                        r.nxt.rem = 2'd1;
                    end else if (b[7:4] == 4'hE) begin
                        r.nxt.acc = {17'd0, b[3:0]};
                        r.nxt.rem = 2'd2;
                    end else begin
                        r.nxt.acc = {18'd0, b[2:0]};
                        r.nxt.rem = 2'd3;
                    end
                end else begin
                    r.nxt.acc = acc_n;
                    r.nxt.rem = s.nxt.rem - 2'd1;
                    if (s.nxt.rem == 2'd1) begin
                        r = bsd_give(r, acc_n);
                    end
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    // full effect of one request on the decoder state and the results it causes
    function automatic t_step bsd_step(input t_dstate s, input logic has,
                                       input logic [7:0] b, input logic fin);
        t_step       r;
        logic [15:0] word;
        r     = '{nxt: s, out: '0};
        word  = {b, s.held};
        if (has && !s.done) begin
            unique case (s.phase)
                PH_FIRST: begin
                    r.nxt.held  = b;
                    r.nxt.phase = PH_SECOND;
                end
                PH_SECOND: begin
                    r.nxt.held  = 8'd0;
                    r.nxt.phase = PH_DECODE;
                    if (word == WORD_BYTECODE) begin
                        r = bsd_finish(r, ST_BYTECODE);
                    end else if (word == WORD_SWAPPED) begin
                        r.nxt.mode = MODE_BE;
                    end else if (word == WORD_NATIVE) begin
                        r.nxt.mode = MODE_LE;
                    end else if (word == WORD_UTF8_BOM) begin
                        r.nxt.phase = PH_BOM3;
                    end else begin
                        // no mark: replay both bytes as plain text
                        r.nxt.mode = MODE_PLAIN;
                        r = bsd_give(r, {13'd0, s.held});
                        if (!r.nxt.done) begin
                            r = bsd_give(r, {13'd0, b});
                        end
                    end
                end
                PH_BOM3: begin
                    if (b == BYTE_UTF8_END) begin
                        r.nxt.mode  = MODE_UTF8;
                        r.nxt.phase = PH_DECODE;
                    end else begin
                        r = bsd_finish(r, ST_UNKNOWN);
                    end
                end
                PH_DECODE: begin
                    r = bsd_decode(r, b);
                end
                default: r = r;
            endcase
        end
        if (fin) begin
            if (!r.nxt.done && r.nxt.phase == PH_SECOND) begin
                r = bsd_give(r, {13'd0, r.nxt.held});
            end
            if (!r.nxt.done) begin
                r = bsd_finish(r, (r.nxt.phase == PH_BOM3) ? ST_IOERR : ST_EOS);
            end
            r.nxt = DSTATE_RST;
        end
        return r;
    endfunction

endpackage

// File: design/bsd_front.sv
// front end: takes requests, tracks bom and decode state, builds result bundles
// depends on bsd_pkg
module bsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_has_byte,
    input  logic [7:0]      i_data_byte,
    input  logic            i_final_byte,
    output bsd_pkg::t_qport o_push
);
    import bsd_pkg::*;

    t_dstate r_state;
    t_dstate n_state;
    t_step   w_step;
    t_bundle w_out;

    assign w_step = bsd_step(r_state, i_has_byte, i_data_byte, i_final_byte);

    // next state
    always_comb begin
        n_state = r_state;
        if (i_take) begin
            n_state = w_step.nxt;
        end
    end

    // outputs
    always_comb begin
        w_out        = w_step.out;
        o_push.valid = i_take && (w_out.cnt != 2'd0);
        o_push.data  = w_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DSTATE_RST;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/bsd_queue.sv
// bundle queue between front and back end
// depends on bsd_pkg
module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsd_pkg::t_qport i_push,
    input  logic            i_pop,
    output logic            o_full,
    output bsd_pkg::t_qport o_head
);
    import bsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data = r_mem[r_rptr];
    assign w_wr        = i_push.valid && !o_full;
    assign w_rd        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/bsd_back.sv
// back end: walks the head bundle and hands out its results one at a time, held by i_stall
// depends on bsd_pkg
module bsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsd_pkg::t_qport               i_head,
    input  logic                          i_stall,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [bsd_pkg::CODE_W-1:0]    o_char_code,
    output logic [2:0]                    o_status,
    output logic                          o_last_result
);
    import bsd_pkg::*;

    logic [1:0] r_idx;
    logic       w_take;
    t_res       w_cur;

    assign w_cur         = i_head.data.res[r_idx];
    assign o_valid       = i_head.valid;
    assign o_char_code   = w_cur.code;
    assign o_status      = w_cur.status;
    assign o_last_result = (r_idx == i_head.data.cnt - 2'd1);
    assign w_take        = o_valid && !i_stall;
    assign o_pop         = w_take && o_last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (w_take) begin
            r_idx <= o_last_result ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// File: design/bom_sniffing_text_decoder.sv
// top level of the bom sniffing text decoder: front end, bundle queue, back end
// depends on bsd_pkg, bsd_front, bsd_queue, bsd_back
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall  | i_has_byte, i_data_byte, i_final_byte
//  result  | out       | o_valid / i_stall  | o_char_code, o_status, o_last_result
//
// one input byte is taken every cycle while the bundle queue has room
// a request occupies the result port once per result it causes (one to three);
// requests that cause no result never reach the back end
// sustained rate is set by the single result port draining the queue
// reset is synchronous, active low, and clears the decoder state, queue and result index
// o_stall rises only when the queue is full; i_stall holds the current result in place
module bom_sniffing_text_decoder #(
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_has_byte,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_final_byte,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bsd_pkg::CODE_W-1:0] o_char_code,
    output logic [2:0]                 o_status,
    output logic                       o_last_result
);
    import bsd_pkg::*;

    t_qport w_push;   // bundle built by the front end for this request
    t_qport w_head;   // oldest bundle waiting for the result port
    logic   w_full;
    logic   w_pop;
    logic   w_take;

    // a request is taken whenever the queue can hold whatever it causes
    assign o_stall = w_full;
    assign w_take  = i_valid && !w_full;

    // front end: bom sniffing, utf-8 / utf-16 / plain decode, end of buffer handling
    bsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_has_byte   (i_has_byte),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (w_push)
    );

    // decouples byte intake from result drain
    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // back end: serializes each bundle onto the result port, marks its last result
    bsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_stall       (i_stall),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_char_code   (o_char_code),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

endmodule
